// ===== src/hfs_pkg.sv =====
// hfs_pkg: shared constants, register codes and bundle types for the
// heat_five_point_stencil block. No dependencies; every other file imports it.
package hfs_pkg;

    // default sizes handed to the top-level parameters
    localparam int MAX_COLS_DEF    = 1024;
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    // fixed field widths
    localparam int INDEX_W     = 10;
    localparam int SIZE_W      = 11;
    localparam int WEIGHT_W    = 15;
    localparam int WEIGHT_FRAC = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // smallest grid that has an interior point
    localparam int MIN_GRID = 3;

    // 1.0 in the weight format, and the width that holds 1 - 2wx - 2wy
    localparam int ONE_Q    = 1 << WEIGHT_FRAC;
    localparam int CENTRE_W = WEIGHT_FRAC + 2;

    // register reset values
    localparam logic [SIZE_W-1:0]   GRID_ROWS_RST = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0]   GRID_COLS_RST = SIZE_W'(1024);
    localparam logic [INDEX_W-1:0]  FIRST_ROW_RST = INDEX_W'(1);
    localparam logic [INDEX_W-1:0]  LAST_ROW_RST  = INDEX_W'(1022);
    localparam logic [INDEX_W-1:0]  FIRST_COL_RST = INDEX_W'(1);
    localparam logic [INDEX_W-1:0]  LAST_COL_RST  = INDEX_W'(1022);
    localparam logic [WEIGHT_W-1:0] WGT_NS_RST    = WEIGHT_W'(16384);
    localparam logic [WEIGHT_W-1:0] WGT_WE_RST    = WEIGHT_W'(16384);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_ROWS = 3'd0,
        REG_GRID_COLS = 3'd1,
        REG_FIRST_ROW = 3'd2,
        REG_LAST_ROW  = 3'd3,
        REG_FIRST_COL = 3'd4,
        REG_LAST_COL  = 3'd5,
        REG_WGT_NS    = 3'd6,
        REG_WGT_WE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   grid_rows;
        logic [SIZE_W-1:0]   grid_cols;
        logic [INDEX_W-1:0]  first_row;
        logic [INDEX_W-1:0]  last_row;
        logic [INDEX_W-1:0]  first_col;
        logic [INDEX_W-1:0]  last_col;
        logic [WEIGHT_W-1:0] wgt_ns;
        logic [WEIGHT_W-1:0] wgt_we;
    } hfs_cfg_t;

    // tag that travels with each point through the arithmetic stages
    typedef struct packed {
        logic               last;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
    } hfs_tag_t;

endpackage

// ===== src/hfs_front.sv =====
// hfs_front: raster counters, two-row line buffer and neighbor window.
// Produces the five operands and the point tag for each interior point inside the row and column window.
// Depends on hfs_pkg.
module hfs_front #(
    parameter int MAX_COLS    = hfs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = hfs_pkg::MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = hfs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hfs_pkg::hfs_cfg_t       cfg,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output logic                    pt_valid,
    input  logic                    pt_ready,
    output hfs_pkg::hfs_tag_t       pt_tag,
    output logic [SAMPLE_BITS-1:0]  op_north,
    output logic [SAMPLE_BITS-1:0]  op_south,
    output logic [SAMPLE_BITS-1:0]  op_west,
    output logic [SAMPLE_BITS-1:0]  op_east,
    output logic [SAMPLE_BITS-1:0]  op_centre
);
    import hfs_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    // compare widths: hold the counter plus one and the size registers
    localparam int CCW   = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
    localparam int RCW   = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;
    localparam int SB    = SAMPLE_BITS;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CCW-1:0]    cols_clamped, col_inc;
    logic [RCW-1:0]    rows_clamped, row_inc;

    logic              s1_valid_reg;
    logic [SB-1:0]     s1_sample_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [2*SB-1:0]   rd_reg;

    // each entry holds {older row, newer row} for one column
    logic [2*SB-1:0]   line_mem [MAX_COLS];

    logic [SB-1:0]     win_north_reg, win_centre_reg, win_west_reg, win_south_reg;

    logic              s2_valid_reg;
    hfs_tag_t          s2_tag_reg;
    logic [SB-1:0]     north_reg, south_reg, west_reg, east_reg, centre_reg;

    logic              accept, s2_free, s1_adv;
    logic [RCW-1:0]    pr, rows_m2, row_end;
    logic [CCW-1:0]    pc, cols_m2, col_end;
    logic              emit, is_last;

    assign s2_free      = !s2_valid_reg || pt_ready;
    assign sample_ready = !s1_valid_reg || s2_free;
    assign accept       = sample_valid && sample_ready;
    assign s1_adv       = s1_valid_reg && s2_free;

    // grid sizes clamped to what the buffers hold
    always_comb
    begin
        priority if (CCW'(cfg.grid_cols) < CCW'(MIN_GRID))
            cols_clamped = CCW'(MIN_GRID);
        else if (CCW'(cfg.grid_cols) > CCW'(MAX_COLS))
            cols_clamped = CCW'(MAX_COLS);
        else
            cols_clamped = CCW'(cfg.grid_cols);

        priority if (RCW'(cfg.grid_rows) < RCW'(MIN_GRID))
            rows_clamped = RCW'(MIN_GRID);
        else if (RCW'(cfg.grid_rows) > RCW'(MAX_ROWS))
            rows_clamped = RCW'(MAX_ROWS);
        else
            rows_clamped = RCW'(cfg.grid_rows);
    end

    // raster position of the next sample
    always_comb
    begin
        col_inc = CCW'(col_reg) + CCW'(1);
        row_inc = RCW'(row_reg);
        if (col_inc >= cols_clamped)
        begin
            col_inc = '0;
            row_inc = RCW'(row_reg) + RCW'(1);
        end
        if (row_inc >= rows_clamped)
            row_inc = '0;
        col_next = col_inc[COL_W-1:0];
        row_next = row_inc[ROW_W-1:0];
    end

    // the sample in stage 1 completes point (row-1, col-1)
    assign pr      = RCW'(s1_row_reg) - RCW'(1);
    assign pc      = CCW'(s1_col_reg) - CCW'(1);
    assign rows_m2 = rows_clamped - RCW'(2);
    assign cols_m2 = cols_clamped - CCW'(2);
    assign row_end = (RCW'(cfg.last_row) < rows_m2) ? RCW'(cfg.last_row) : rows_m2;
    assign col_end = (CCW'(cfg.last_col) < cols_m2) ? CCW'(cfg.last_col) : cols_m2;

    assign emit = (RCW'(s1_row_reg) >= RCW'(2)) && (CCW'(s1_col_reg) >= CCW'(2))
               && (pr >= RCW'(cfg.first_row)) && (pr <= RCW'(cfg.last_row))
               && (pc >= CCW'(cfg.first_col)) && (pc <= CCW'(cfg.last_col));
    assign is_last = (pr == row_end) && (pc == col_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (sample_ready)
                s1_valid_reg <= sample_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg && emit;
        end
    end

    // line buffer: read on transfer, write back when the sample leaves stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            rd_reg        <= line_mem[col_reg];
        end
        if (s1_adv)
        begin
            line_mem[s1_col_reg] <= {rd_reg[SB-1:0], s1_sample_reg};
            win_west_reg         <= win_centre_reg;
            win_centre_reg       <= rd_reg[SB-1:0];
            win_north_reg        <= rd_reg[2*SB-1:SB];
            win_south_reg        <= s1_sample_reg;
        end
        if (s2_free)
        begin
            s2_tag_reg.last <= is_last;
            s2_tag_reg.row  <= pr[INDEX_W-1:0];
            s2_tag_reg.col  <= pc[INDEX_W-1:0];
            north_reg       <= win_north_reg;
            south_reg       <= win_south_reg;
            west_reg        <= win_west_reg;
            east_reg        <= rd_reg[SB-1:0];
            centre_reg      <= win_centre_reg;
        end
    end

    assign pt_valid  = s2_valid_reg;
    assign pt_tag    = s2_tag_reg;
    assign op_north  = north_reg;
    assign op_south  = south_reg;
    assign op_west   = west_reg;
    assign op_east   = east_reg;
    assign op_centre = centre_reg;

endmodule

// ===== src/hfs_datapath.sv =====
// hfs_datapath: four-stage weighted sum of the five-point neighborhood with
// floor truncation and saturation, ending in the output register.
// Depends on hfs_pkg.
module hfs_datapath #(
    parameter int SAMPLE_BITS = hfs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [hfs_pkg::WEIGHT_W-1:0]     wgt_ns,
    input  logic [hfs_pkg::WEIGHT_W-1:0]     wgt_we,
    input  logic                             pt_valid,
    output logic                             pt_ready,
    input  hfs_pkg::hfs_tag_t                pt_tag,
    input  logic [SAMPLE_BITS-1:0]           op_north,
    input  logic [SAMPLE_BITS-1:0]           op_south,
    input  logic [SAMPLE_BITS-1:0]           op_west,
    input  logic [SAMPLE_BITS-1:0]           op_east,
    input  logic [SAMPLE_BITS-1:0]           op_centre,
    output logic                             res_valid,
    input  logic                             res_ready,
    output hfs_pkg::hfs_tag_t                res_tag,
    output logic [SAMPLE_BITS-1:0]           res_value,
    output logic                             res_sat
);
    import hfs_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int PW  = SB + 1 + WEIGHT_W + 1;   // weight times pair sum
    localparam int CPW = SB + CENTRE_W;           // centre weight times centre
    localparam int AW  = SB + 4;

    logic                       v3_reg, v4_reg, v5_reg, v6_reg;
    logic                       free3, free4, free5, free6;
    hfs_tag_t                   tag3_reg, tag4_reg, tag5_reg, tag6_reg;

    logic signed [SB:0]         ns3_reg, we3_reg;
    logic signed [SB-1:0]       c3_reg;
    logic signed [CENTRE_W-1:0] cw3_reg;

    logic signed [PW-1:0]       p1_reg, p2_reg;
    logic signed [CPW-1:0]      p3_reg;

    logic signed [PW-WEIGHT_FRAC-1:0]  t1, t2;
    logic signed [CPW-WEIGHT_FRAC-1:0] t3;
    logic signed [AW-1:0]       acc5_reg;

    logic [AW-SB:0]             acc_top;
    logic                       sat_next;
    logic [SB-1:0]              value_next;
    logic [SB-1:0]              value6_reg;
    logic                       sat6_reg;

    assign free6    = !v6_reg || res_ready;
    assign free5    = !v5_reg || free6;
    assign free4    = !v4_reg || free5;
    assign free3    = !v3_reg || free4;
    assign pt_ready = free3;

    // arithmetic shift is floor division by 2^16
    assign t1 = p1_reg[PW-1:WEIGHT_FRAC];
    assign t2 = p2_reg[PW-1:WEIGHT_FRAC];
    assign t3 = p3_reg[CPW-1:WEIGHT_FRAC];

    // in range when every bit above the sign bit matches it
    assign acc_top  = acc5_reg[AW-1:SB-1];
    assign sat_next = !((&acc_top) || !(|acc_top));
    always_comb
    begin
        if (!sat_next)
            value_next = acc5_reg[SB-1:0];
        else if (acc5_reg[AW-1])
            value_next = {1'b1, {(SB-1){1'b0}}};
        else
            value_next = {1'b0, {(SB-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (free3)
                v3_reg <= pt_valid;
            if (free4)
                v4_reg <= v3_reg;
            if (free5)
                v5_reg <= v4_reg;
            if (free6)
                v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            tag3_reg <= pt_tag;
            ns3_reg  <= $signed({op_north[SB-1], op_north}) + $signed({op_south[SB-1], op_south});
            we3_reg  <= $signed({op_west[SB-1], op_west}) + $signed({op_east[SB-1], op_east});
            c3_reg   <= $signed(op_centre);
            cw3_reg  <= $signed(CENTRE_W'(ONE_Q) - CENTRE_W'({wgt_ns, 1'b0})
                                - CENTRE_W'({wgt_we, 1'b0}));
        end
        if (free4)
        begin
            tag4_reg <= tag3_reg;
            p1_reg   <= $signed({1'b0, wgt_ns}) * ns3_reg;
            p2_reg   <= $signed({1'b0, wgt_we}) * we3_reg;
            p3_reg   <= cw3_reg * c3_reg;
        end
        if (free5)
        begin
            tag5_reg <= tag4_reg;
            acc5_reg <= AW'(t1) + AW'(t2) + AW'(t3);
        end
        if (free6)
        begin
            tag6_reg   <= tag5_reg;
            value6_reg <= value_next;
            sat6_reg   <= sat_next;
        end
    end

    assign res_valid = v6_reg;
    assign res_tag   = tag6_reg;
    assign res_value = value6_reg;
    assign res_sat   = sat6_reg;

endmodule

// ===== src/heat_five_point_stencil.sv =====
// heat_five_point_stencil: one explicit heat-equation step over a raster grid.
// Holds the configuration registers; instantiates hfs_front and hfs_datapath.
// Depends on hfs_pkg.
//
// Usage: samples stream in raster order over the whole grid, halo rows and
// columns included, on the sample channel (valid/ready). For every interior
// point inside the configured row and column window one result leaves on the
// result channel (valid/ready) with its row, column, new value, a saturation
// flag and a last flag on the final point of the window. Samples on the halo
// or outside the window produce no result.
// A point is completed by the sample one row below and one column right of
// it; its result is registered through every stage into the output register.
// Throughput is one sample per cycle: the line buffer gives one read and one
// write per cycle, and every stage takes a new item each cycle.
// When the receiver stalls, results wait in the output register and the
// stages before it fill their empty slots; the sample channel drops ready
// only when every stage holds an item. Reset clears the raster counters and
// the stage valid bits and loads the register defaults; the line buffer needs
// no clearing. The user must write registers only while the block is idle,
// through cfg_write/cfg_index/cfg_data; the block does not enforce it.
module heat_five_point_stencil #(
    parameter int MAX_COLS    = hfs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = hfs_pkg::MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = hfs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [hfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [hfs_pkg::INDEX_W-1:0]         row_index,
    output logic [hfs_pkg::INDEX_W-1:0]         col_index,
    output logic signed [SAMPLE_BITS-1:0]       new_value,
    output logic                                saturated,
    output logic                                last
);
    import hfs_pkg::*;

    hfs_cfg_t               cfg_reg;
    logic                   pt_valid, pt_ready;
    hfs_tag_t               pt_tag, res_tag;
    logic [SAMPLE_BITS-1:0] op_north, op_south, op_west, op_east, op_centre;
    logic [SAMPLE_BITS-1:0] res_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_rows <= GRID_ROWS_RST;
            cfg_reg.grid_cols <= GRID_COLS_RST;
            cfg_reg.first_row <= FIRST_ROW_RST;
            cfg_reg.last_row  <= LAST_ROW_RST;
            cfg_reg.first_col <= FIRST_COL_RST;
            cfg_reg.last_col  <= LAST_COL_RST;
            cfg_reg.wgt_ns    <= WGT_NS_RST;
            cfg_reg.wgt_we    <= WGT_WE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_ROWS: cfg_reg.grid_rows <= cfg_data[SIZE_W-1:0];
                REG_GRID_COLS: cfg_reg.grid_cols <= cfg_data[SIZE_W-1:0];
                REG_FIRST_ROW: cfg_reg.first_row <= cfg_data[INDEX_W-1:0];
                REG_LAST_ROW:  cfg_reg.last_row  <= cfg_data[INDEX_W-1:0];
                REG_FIRST_COL: cfg_reg.first_col <= cfg_data[INDEX_W-1:0];
                REG_LAST_COL:  cfg_reg.last_col  <= cfg_data[INDEX_W-1:0];
                REG_WGT_NS:    cfg_reg.wgt_ns    <= cfg_data[WEIGHT_W-1:0];
                REG_WGT_WE:    cfg_reg.wgt_we    <= cfg_data[WEIGHT_W-1:0];
            endcase
        end
    end

    hfs_front #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .pt_valid     (pt_valid),
        .pt_ready     (pt_ready),
        .pt_tag       (pt_tag),
        .op_north     (op_north),
        .op_south     (op_south),
        .op_west      (op_west),
        .op_east      (op_east),
        .op_centre    (op_centre)
    );

    hfs_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wgt_ns    (cfg_reg.wgt_ns),
        .wgt_we    (cfg_reg.wgt_we),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt_tag    (pt_tag),
        .op_north  (op_north),
        .op_south  (op_south),
        .op_west   (op_west),
        .op_east   (op_east),
        .op_centre (op_centre),
        .res_valid (result_valid),
        .res_ready (result_ready),
        .res_tag   (res_tag),
        .res_value (res_value),
        .res_sat   (saturated)
    );

    assign row_index = res_tag.row;
    assign col_index = res_tag.col;
    assign last      = res_tag.last;
    assign new_value = $signed(res_value);

endmodule

// ===== tb/heat_five_point_stencil_tb.sv =====
// heat_five_point_stencil_tb: self-checking bench for the five-point heat stencil
// with a valid/ready driver and sink, a bit-true stencil predictor and a result checker.
// Depends on hfs_pkg and heat_five_point_stencil.
module heat_five_point_stencil_tb;

    import hfs_pkg::*;

    localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
    localparam int MAX_COLS       = MAX_COLS_DEF;
    localparam int MAX_ROWS       = MAX_ROWS_DEF;
    localparam int RANDOM_SAMPLES = 1400;
    localparam int SETTLE_CYCLES  = 12;
    localparam int MAX_WAIT       = 16;
    localparam int QUARTER_Q      = ONE_Q / 4;
    localparam int WEIGHT_TOP     = (1 << WEIGHT_W) - 1;
    localparam int INDEX_TOP      = (1 << INDEX_W) - 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint VALUE_MAX = SAMPLE_HI;
    localparam longint VALUE_MIN = SAMPLE_LO;

    typedef enum {FILL_RANDOM, FILL_MAX, FILL_SPIKE, FILL_ALTERNATE} fill_t;

    typedef struct {
        logic [INDEX_W-1:0]         row;
        logic [INDEX_W-1:0]         col;
        logic signed [SAMPLE_W-1:0] value;
        logic                       sat;
        logic                       last_pt;
    } heat_point_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_write    = 1'b0;
    cfg_reg_t                    cfg_index    = REG_GRID_ROWS;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;
    logic                        sample_valid = 1'b0;
    logic                        sample_ready;
    logic signed [SAMPLE_W-1:0]  sample       = '0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    logic [INDEX_W-1:0]          row_index;
    logic [INDEX_W-1:0]          col_index;
    logic signed [SAMPLE_W-1:0]  new_value;
    logic                        saturated;
    logic                        last;

    heat_five_point_stencil i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .row_index    (row_index),
        .col_index    (col_index),
        .new_value    (new_value),
        .saturated    (saturated),
        .last         (last)
    );

    always #5 clk = ~clk;

    // predictor state: register copy, line buffers, raster position, neighbour window
    hfs_cfg_t cfg_now = '{GRID_ROWS_RST, GRID_COLS_RST, FIRST_ROW_RST, LAST_ROW_RST,
                          FIRST_COL_RST, LAST_COL_RST, WGT_NS_RST, WGT_WE_RST};
    logic signed [SAMPLE_W-1:0] far_line  [MAX_COLS] = '{default: '0};
    logic signed [SAMPLE_W-1:0] near_line [MAX_COLS] = '{default: '0};
    int unsigned                row_pos = 0;
    int unsigned                col_pos = 0;
    logic signed [SAMPLE_W-1:0] win_n = '0, win_c = '0, win_w = '0, win_s = '0;

    logic signed [SAMPLE_W-1:0] sample_backlog [$];
    heat_point_t                pending_points [$];

    bit tx_busy  = 1'b0;
    bit rx_busy  = 1'b0;
    int hold_req = 0;
    int tx_gap   = 0;
    int rx_stall = 0;
    int rx_hold  = 0;

    int samples_queued = 0;
    int samples_in     = 0;
    int points_checked = 0;
    int sat_seen       = 0;
    int last_seen      = 0;
    int config_cnt     = 0;
    int error_cnt      = 0;

    function automatic int unsigned grid_span(input logic [SIZE_W-1:0] v, input int hi);
        if (v < MIN_GRID) return MIN_GRID;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int draw_wait(input bit busy);
        return busy ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // one FTCS step on the streamed sample; returns 1 when an interior point in the window completes
    function automatic bit stencil_update(input logic signed [SAMPLE_W-1:0] s,
                                          output heat_point_t pt);
        int unsigned rows, cols, r, c, er, ec;
        logic signed [SAMPLE_W-1:0] above, mid;
        longint centre_w, acc;
        bit hit;
        rows = grid_span(cfg_now.grid_rows, MAX_ROWS);
        cols = grid_span(cfg_now.grid_cols, MAX_COLS);
        r = row_pos;
        c = col_pos;
        above = far_line[c];
        mid = near_line[c];
        hit = 1'b0;
        pt = '{row: '0, col: '0, value: '0, sat: 1'b0, last_pt: 1'b0};
        if (r >= 2 && c >= 2 && r - 1 >= cfg_now.first_row && r - 1 <= cfg_now.last_row
            && c - 1 >= cfg_now.first_col && c - 1 <= cfg_now.last_col) begin
            centre_w = longint'(ONE_Q) - 2 * longint'(cfg_now.wgt_ns)
                       - 2 * longint'(cfg_now.wgt_we);
            // each product floors to the sample format before the sum
            acc = ((longint'(cfg_now.wgt_ns) * (longint'(win_n) + longint'(win_s)))
                      >>> WEIGHT_FRAC)
                + ((longint'(cfg_now.wgt_we) * (longint'(win_w) + longint'(mid)))
                      >>> WEIGHT_FRAC)
                + ((centre_w * longint'(win_c)) >>> WEIGHT_FRAC);
            if (acc > VALUE_MAX) begin
                acc = VALUE_MAX;
                pt.sat = 1'b1;
            end
            else if (acc < VALUE_MIN) begin
                acc = VALUE_MIN;
                pt.sat = 1'b1;
            end
            er = (cfg_now.last_row < rows - 2) ? cfg_now.last_row : rows - 2;
            ec = (cfg_now.last_col < cols - 2) ? cfg_now.last_col : cols - 2;
            pt.row = INDEX_W'(r - 1);
            pt.col = INDEX_W'(c - 1);
            pt.value = acc[SAMPLE_W-1:0];
            pt.last_pt = (r - 1 == er) && (c - 1 == ec);
            hit = 1'b1;
        end
        far_line[c] = mid;
        near_line[c] = s;
        win_w = win_c;
        win_c = mid;
        win_n = above;
        win_s = s;
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
        end
        if (r >= rows) r = 0;
        col_pos = c;
        row_pos = r;
        return hit;
    endfunction

    // sample channel driver
    always @(posedge clk or negedge rst_n) begin : sample_driver
        heat_point_t pt;
        if (!rst_n) begin
            sample_valid <= 1'b0;
            sample <= '0;
            tx_gap <= 0;
        end
        else begin
            if (sample_valid && sample_ready) begin
                samples_in++;
                if (stencil_update(sample, pt)) pending_points.push_back(pt);
            end
            if (!sample_valid || sample_ready) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    sample_valid <= 1'b0;
                end
                else if (sample_backlog.size() != 0) begin
                    sample_valid <= 1'b1;
                    sample <= sample_backlog.pop_front();
                    tx_gap <= draw_wait(tx_busy);
                end
                else begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // result channel ready: per-transfer stalls plus the long hold on request
    always @(posedge clk or negedge rst_n) begin : result_sink
        int pause;
        if (!rst_n) begin
            result_ready <= 1'b0;
            rx_stall <= 0;
            rx_hold <= 0;
        end
        else if (hold_req != 0) begin
            rx_hold <= hold_req;
            hold_req = 0;
            result_ready <= 1'b0;
        end
        else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            result_ready <= 1'b0;
        end
        else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            result_ready <= 1'b0;
        end
        else if (result_valid && result_ready) begin
            pause = draw_wait(rx_busy);
            result_ready <= (pause == 0);
            rx_stall <= (pause == 0) ? 0 : pause - 1;
        end
        else begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        heat_point_t want;
        if (rst_n && result_valid && result_ready) begin
            if (pending_points.size() == 0) begin
                if (error_cnt < 10)
                    $display("unexpected result: row %0d col %0d value %h sat %b last %b",
                             row_index, col_index, new_value, saturated, last);
                error_cnt++;
            end
            else begin
                want = pending_points.pop_front();
                points_checked++;
                if (saturated) sat_seen++;
                if (last) last_seen++;
                if (row_index !== want.row || col_index !== want.col
                    || new_value !== want.value || saturated !== want.sat
                    || last !== want.last_pt) begin
                    if (error_cnt < 10)
                        $display({"mismatch: expected row %0d col %0d value %h sat %b last %b,",
                                  " got row %0d col %0d value %h sat %b last %b"},
                                 want.row, want.col, want.value, want.sat, want.last_pt,
                                 row_index, col_index, new_value, saturated, last);
                    error_cnt++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (sample_backlog.size() != 0 || sample_valid || pending_points.size() != 0)
            @(negedge clk);
    endtask

    // upper data bits above a register's width are filled with noise
    task automatic write_reg(input cfg_reg_t which, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        case (which)
            REG_GRID_ROWS: begin
                data[SIZE_W-1:0] = SIZE_W'(value);
                cfg_now.grid_rows = data[SIZE_W-1:0];
            end
            REG_GRID_COLS: begin
                data[SIZE_W-1:0] = SIZE_W'(value);
                cfg_now.grid_cols = data[SIZE_W-1:0];
            end
            REG_FIRST_ROW: begin
                data[INDEX_W-1:0] = INDEX_W'(value);
                cfg_now.first_row = data[INDEX_W-1:0];
            end
            REG_LAST_ROW: begin
                data[INDEX_W-1:0] = INDEX_W'(value);
                cfg_now.last_row = data[INDEX_W-1:0];
            end
            REG_FIRST_COL: begin
                data[INDEX_W-1:0] = INDEX_W'(value);
                cfg_now.first_col = data[INDEX_W-1:0];
            end
            REG_LAST_COL: begin
                data[INDEX_W-1:0] = INDEX_W'(value);
                cfg_now.last_col = data[INDEX_W-1:0];
            end
            REG_WGT_NS: begin
                data = CFG_DATA_W'(value);
                cfg_now.wgt_ns = data[WEIGHT_W-1:0];
            end
            default: begin
                data = CFG_DATA_W'(value);
                cfg_now.wgt_we = data[WEIGHT_W-1:0];
            end
        endcase
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data <= data;
    endtask

    // only at a grid boundary with the pipeline empty
    task automatic set_config(input int rows_v, input int cols_v, input int fr, input int lr,
                              input int fc, input int lc, input int wx, input int wy);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_GRID_ROWS, rows_v);
        write_reg(REG_GRID_COLS, cols_v);
        write_reg(REG_FIRST_ROW, fr);
        write_reg(REG_LAST_ROW, lr);
        write_reg(REG_FIRST_COL, fc);
        write_reg(REG_LAST_COL, lc);
        write_reg(REG_WGT_NS, wx);
        write_reg(REG_WGT_WE, wy);
        @(posedge clk);
        cfg_write <= 1'b0;
        config_cnt++;
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_HI;
            1: return SAMPLE_LO;
            2, 3: return SAMPLE_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // queues one whole grid; optionally stops halfway until every result is back
    task automatic push_grid(input fill_t fill, input bit pause_mid);
        int total;
        logic signed [SAMPLE_W-1:0] s;
        total = grid_span(cfg_now.grid_rows, MAX_ROWS) * grid_span(cfg_now.grid_cols, MAX_COLS);
        for (int i = 0; i < total; i++) begin
            if (pause_mid && i == total / 2) wait_drained();
            case (fill)
                FILL_MAX:       s = SAMPLE_HI;
                FILL_SPIKE:     s = (i == total / 2) ? SAMPLE_LO : SAMPLE_HI;
                FILL_ALTERNATE: s = i[0] ? SAMPLE_HI : SAMPLE_LO;
                default:        s = random_sample();
            endcase
            sample_backlog.push_back(s);
        end
        samples_queued += total;
    endtask

    function automatic int pick_size(input int typical, input int wide);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, MIN_GRID - 1);
            1: return $urandom_range(MIN_GRID, wide);
            default: return $urandom_range(MIN_GRID, typical);
        endcase
    endfunction

    function automatic int pick_bound(input int size);
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, INDEX_TOP);
        return $urandom_range(0, size - 1);
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return QUARTER_Q;
            2: return WEIGHT_TOP;
            3: return $urandom_range(0, WEIGHT_TOP);
            default: return $urandom_range(0, QUARTER_Q);
        endcase
    endfunction

    initial begin : stimulus
        int rows_v, cols_v, fr, lr, fc, lc, grids, phase, random_base;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // sizes below the minimum clamp to 3, window reaches past the grid
        set_config(MIN_GRID - 1, 0, 0, INDEX_TOP, 0, INDEX_TOP, QUARTER_Q, QUARTER_Q);
        push_grid(FILL_MAX, 1'b0);
        // largest weights give a negative centre weight and clip
        set_config(MIN_GRID, MIN_GRID, 1, 1022, 1, 1022, WEIGHT_TOP, WEIGHT_TOP);
        push_grid(FILL_SPIKE, 1'b0);
        // empty column window: the whole grid passes without a result
        set_config(MIN_GRID, MIN_GRID, 1, 1, 2, 1, 0, 0);
        push_grid(FILL_ALTERNATE, 1'b0);

        phase = 0;
        random_base = samples_queued;
        while (phase < 2 || samples_queued - random_base < RANDOM_SAMPLES) begin
            rows_v = pick_size(8, 20);
            cols_v = pick_size(12, 40);
            fr = pick_bound(grid_span(SIZE_W'(rows_v), MAX_ROWS));
            lr = pick_bound(grid_span(SIZE_W'(rows_v), MAX_ROWS));
            fc = pick_bound(grid_span(SIZE_W'(cols_v), MAX_COLS));
            lc = pick_bound(grid_span(SIZE_W'(cols_v), MAX_COLS));
            if (phase == 0 || $urandom_range(0, 5) == 0) begin
                fr = 1;
                lr = 1022;
                fc = 1;
                lc = 1022;
            end
            set_config(rows_v, cols_v, fr, lr, fc, lc, pick_weight(), pick_weight());
            tx_busy = ($urandom_range(0, 3) == 0);
            rx_busy = ($urandom_range(0, 3) == 0);
            grids = $urandom_range(1, 3);
            for (int g = 0; g < grids && (g == 0 || samples_queued - random_base
                                          < RANDOM_SAMPLES); g++) begin
                // sink holds off while the source keeps offering, so the pipe backs up
                if ((phase == 0 && g == 0) || $urandom_range(0, 9) == 0) begin
                    tx_busy = 1'b1;
                    hold_req = $urandom_range(100, 300);
                end
                push_grid(FILL_RANDOM, (phase == 1 && g == 0) || $urandom_range(0, 7) == 0);
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(negedge clk);
        $display("summary: %0d samples over %0d register settings, %0d points checked",
                 samples_in, config_cnt, points_checked);
        $display("summary: %0d clipped results, %0d end-of-window flags, %0d errors",
                 sat_seen, last_seen, error_cnt);
        if (error_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #15000000;
        $display("tb: failure");
        $finish;
    end

endmodule
